/* rtl/bse_pkg.sv */
// Shared types and constants for the binary search engine.
package bse_pkg;

  // Command codes carried by the input transaction.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Field widths that the interface fixes.
  localparam int IDX_W   = 10;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 11;
  localparam int PROBE_W = 4;

  typedef struct packed {
    logic                     command;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   found_position;
    logic [PROBE_W-1:0] compare_count;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr;
    logic load;
    logic rd;
    logic step;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic eq;
    logic range_done;
  } dp_status_t;

endpackage

/* rtl/binary_search_engine.sv */
// Top level of the binary search engine: controller, datapath and checks.
//
// Usage: each input transaction carries a command, a table position and a
// signed 32-bit value. A write transaction stores the value at the position
// (positions at or past TABLE_DEPTH are dropped) and gives no result. A
// search transaction runs a binary search over entries 0 to entry_count-1
// (counts past TABLE_DEPTH saturate) and gives one result transaction:
// found, found_position, compare_count. entry_count is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, as
// the block itself does not enforce this. Each probe is a registered read
// of the single-port table in ST_READ followed by a compare in ST_CMP. Once
// the result is loaded the controller returns to ST_IDLE, where the next
// transaction is accepted.
// Reset (synchronous, rst_n low) clears entry_count and the control state;
// table contents are undefined until written. While the receiver stalls, the
// result holds and the block still accepts write transactions and one more
// search; a finished second search waits with in_stall high until the result
// is taken.
module binary_search_engine #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bse_pkg::COUNT_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bse_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bse_pkg::out_item_t          out_data
);

  bse_pkg::dp_cmd_t    cmd;
  bse_pkg::dp_status_t status;

  bse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .cmd        (cmd)
  );

  bse_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

  // A write transaction never produces a result.
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.command == bse_pkg::CMD_WRITE) && !out_valid
    |=> !out_valid)
    else $error("result appeared after a write transaction");

  // A search in progress blocks further input.
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.command == bse_pkg::CMD_SEARCH)
    |=> in_stall)
    else $error("input accepted while a search was in progress");

  // A miss reports position zero.
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> (out_data.found_position == '0))
    else $error("miss reported a nonzero position");

endmodule

/* rtl/bse_ctrl.sv */
// Controller state machine for the binary search engine.
module bse_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  bse_pkg::dp_status_t status,
  output bse_pkg::dp_cmd_t    cmd
);

  bse_pkg::state_t state_r;
  bse_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            take;
  logic            out_free;

  // An input transaction is taken only while idle.
  assign take     = (state_r == bse_pkg::ST_IDLE) && in_valid;
  assign out_free = !out_valid_r || !out_stall;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bse_pkg::ST_IDLE: begin
        if (take && (in_command == bse_pkg::CMD_SEARCH)) begin
          state_nxt = status.count_zero ? bse_pkg::ST_FINISH : bse_pkg::ST_READ;
        end
      end
      bse_pkg::ST_READ: begin
        state_nxt = bse_pkg::ST_CMP;
      end
      bse_pkg::ST_CMP: begin
        if (status.eq || status.range_done) begin
          state_nxt = bse_pkg::ST_FINISH;
        end else begin
          state_nxt = bse_pkg::ST_READ;
        end
      end
      bse_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = bse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bse_pkg::ST_IDLE;
      end
    endcase
  end

  // Output decode for the datapath commands and the input stall.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      bse_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.wr   = take && (in_command == bse_pkg::CMD_WRITE);
        cmd.load = take && (in_command == bse_pkg::CMD_SEARCH);
      end
      bse_pkg::ST_READ: begin
        cmd.rd = 1'b1;
      end
      bse_pkg::ST_CMP: begin
        cmd.step = 1'b1;
      end
      bse_pkg::ST_FINISH: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // The result register stays valid until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bse_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/bse_datapath.sv */
// Datapath for the binary search engine: table memory, search bounds and result register.
module bse_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bse_pkg::COUNT_W-1:0]     cfg_wdata,
  input  bse_pkg::in_item_t               in_data,
  input  bse_pkg::dp_cmd_t                cmd,
  output bse_pkg::dp_status_t             status,
  output bse_pkg::out_item_t              out_data
);

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int PCW = $clog2(AW + 2);

  logic signed [bse_pkg::DATA_W-1:0] mem [TABLE_DEPTH];

  logic [bse_pkg::COUNT_W-1:0]       entry_count_r;
  logic [CW-1:0]                     count_sat;
  logic signed [bse_pkg::DATA_W-1:0] key_r;
  logic signed [bse_pkg::DATA_W-1:0] rd_data_r;
  logic [CW-1:0]                     lo_r;
  logic [CW-1:0]                     hend_r;
  logic [AW-1:0]                     mid;
  logic [AW-1:0]                     mid_r;
  logic [CW:0]                       mid_sum;
  logic [CW-1:0]                     mid_ext;
  logic [CW-1:0]                     mid_inc;
  logic [PCW-1:0]                    probes_r;
  logic                              hit_r;
  logic [AW-1:0]                     pos_r;
  logic                              gt;
  logic                              eq;
  logic                              wr_in_range;
  logic [AW-1:0]                     wr_addr;
  bse_pkg::out_item_t                out_r;

  // Entry count register; counts past the table depth saturate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_we) begin
      entry_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (32'(entry_count_r) > 32'(TABLE_DEPTH)) begin
      count_sat = CW'(TABLE_DEPTH);
    end else begin
      count_sat = CW'(entry_count_r);
    end
  end

  // Table writes; positions past the depth are dropped.
  assign wr_in_range = (32'(in_data.entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr     = AW'(in_data.entry_index);

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_in_range) begin
      mem[wr_addr] <= in_data.data_value;
    end
  end

  // Middle of the live range [lo, hend), rounded down.
  assign mid_sum = (CW+1)'(lo_r) + (CW+1)'(hend_r) - (CW+1)'(1);
  assign mid     = AW'(mid_sum >> 1);

  // Registered table read at the middle.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[mid];
      mid_r     <= mid;
    end
  end

  // Probe comparison and the emptiness test of the narrowed range.
  assign gt      = key_r > rd_data_r;
  assign eq      = key_r == rd_data_r;
  assign mid_ext = CW'(mid_r);
  assign mid_inc = mid_ext + CW'(1);

  always_comb begin
    status.count_zero = (count_sat == '0);
    status.eq         = eq;
    if (gt) begin
      status.range_done = (mid_inc >= hend_r);
    end else if (!eq) begin
      status.range_done = (lo_r >= mid_ext);
    end else begin
      status.range_done = 1'b1;
    end
  end

  // Search bounds, probe counter and match record.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= in_data.data_value;
      lo_r     <= '0;
      hend_r   <= count_sat;
      probes_r <= '0;
      hit_r    <= 1'b0;
      pos_r    <= '0;
    end else begin
      if (cmd.rd) begin
        probes_r <= probes_r + PCW'(1);
      end
      if (cmd.step) begin
        if (gt) begin
          lo_r <= mid_inc;
        end else if (eq) begin
          hit_r <= 1'b1;
          pos_r <= mid_r;
        end else begin
          hend_r <= mid_ext;
        end
      end
    end
  end

  // Result register, loaded once the receiver has room.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.found          <= hit_r;
      out_r.found_position <= bse_pkg::IDX_W'(pos_r);
      out_r.compare_count  <= bse_pkg::PROBE_W'(probes_r);
    end
  end

  assign out_data = out_r;

endmodule

/* tb/binary_search_checker.sv */
// Checker for the binary search engine: predicts each search result and compares it.
module binary_search_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bse_pkg::COUNT_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  bse_pkg::in_item_t           in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  bse_pkg::out_item_t          out_data,
  output int                          fail_count,
  output int                          outstanding
);

  localparam int TABLE_DEPTH = 1024;
  localparam int REPORT_LIMIT = 10;

  // Private copy of the table and of the entry count register.
  logic signed [bse_pkg::DATA_W-1:0] entry_mem [TABLE_DEPTH];
  logic [bse_pkg::COUNT_W-1:0]       entry_count;

  // Predicted results of accepted searches, oldest first.
  bse_pkg::out_item_t predicted_results [$];
  bse_pkg::out_item_t want;
  int                 errors = 0;

  // Binary search over the used part of the table, recomputing the middle per probe.
  function automatic bse_pkg::out_item_t search_table(
    input logic signed [bse_pkg::DATA_W-1:0] key);
    bse_pkg::out_item_t res;
    int                 lo;
    int                 hi;
    int                 mid;
    int                 span;
    res = '0;
    span = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
    lo = 0;
    hi = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      res.compare_count = res.compare_count + 1'b1;
      if (key > entry_mem[mid[bse_pkg::IDX_W-1:0]]) begin
        lo = mid + 1;
      end else if (key == entry_mem[mid[bse_pkg::IDX_W-1:0]]) begin
        res.found = 1'b1;
        res.found_position = mid[bse_pkg::IDX_W-1:0];
        break;
      end else begin
        hi = mid - 1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      entry_count = '0;
      predicted_results.delete();
    end else begin
      // The user must write the register only while the engine is idle; the checker does not enforce this.
      if (cfg_we) begin
        entry_count = cfg_wdata;
      end

      // Each result transaction is matched against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("unexpected result: found=%0d position=%0d probes=%0d",
                     out_data.found, out_data.found_position, out_data.compare_count);
          end
        end else begin
          want = predicted_results.pop_front();
          if (out_data.found !== want.found ||
              out_data.found_position !== want.found_position ||
              out_data.compare_count !== want.compare_count) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("result mismatch: expected found=%0d position=%0d probes=%0d, %s",
                       want.found, want.found_position, want.compare_count, "got:");
              $display("  actual found=%0d position=%0d probes=%0d",
                       out_data.found, out_data.found_position, out_data.compare_count);
            end
          end
        end
      end

      // A write transaction updates the table; a search queues its prediction.
      if (in_valid && !in_stall) begin
        if (in_data.command == bse_pkg::CMD_WRITE) begin
          if (in_data.entry_index < TABLE_DEPTH) begin
            entry_mem[in_data.entry_index] = in_data.data_value;
          end
        end else begin
          predicted_results.push_back(search_table(in_data.data_value));
        end
      end
    end
    outstanding <= predicted_results.size();
    fail_count <= errors;
  end

endmodule

/* tb/binary_search_engine_tb.sv */
// Testbench top for the binary search engine: stimulus, watchdog and verdict.
module binary_search_engine_tb;

  localparam int DEPTH = 1024;
  localparam int SETTLE_CYCLES = 32;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 15;
  localparam int MAX_GAP = 17;
  localparam logic signed [bse_pkg::DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [bse_pkg::DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [bse_pkg::COUNT_W-1:0] cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  bse_pkg::in_item_t           in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  bse_pkg::out_item_t          out_data;
  int                          fail_count;
  int                          outstanding;

  // Stimulus-side view of the table, used to pick keys that hit.
  logic signed [bse_pkg::DATA_W-1:0] shadow [DEPTH];
  int                                span = 0;
  bit                                send_quiet = 1'b0;
  bit                                recv_quiet = 1'b0;
  int                                stall_left = 0;
  int                                idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  binary_search_engine #(.TABLE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  binary_search_checker result_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Present one transaction after a random gap (none when send_quiet is set) and hold it until accepted.
  task automatic send(input logic cmd, input logic [bse_pkg::IDX_W-1:0] idx,
                      input logic signed [bse_pkg::DATA_W-1:0] value);
    int                gap;
    bse_pkg::in_item_t item;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
    item.command = cmd;
    item.entry_index = idx;
    item.data_value = value;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    if (cmd == bse_pkg::CMD_WRITE) begin
      shadow[idx] = value;
    end
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending until every predicted result has come back, then wait a while.
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Change the entry count once the engine has gone quiet.
  task automatic set_count(input logic [bse_pkg::COUNT_W-1:0] value);
    drain(SETTLE_CYCLES);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    span = (value > DEPTH) ? DEPTH : int'(value);
  endtask

  // Keys present in the searched range half the time, else neighbors, extremes and noise.
  function automatic logic signed [bse_pkg::DATA_W-1:0] pick_key();
    int                                sel;
    logic signed [bse_pkg::DATA_W-1:0] k;
    sel = $urandom_range(0, 19);
    if (span > 0 && sel < 14) begin
      k = shadow[bse_pkg::IDX_W'($urandom_range(0, span - 1))];
      if (sel >= 10) begin
        if (sel[0]) k = k + 1;
        else k = k - 1;
      end
    end else if (sel == 14) begin
      k = KEY_MIN;
    end else if (sel == 15) begin
      k = KEY_MAX;
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  // Receiver: after each result, stall for a random number of cycles (none when recv_quiet is set).
  always @(posedge clk) begin : rx_stall
    int wait_len;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      wait_len = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (wait_len > 0) begin
        out_stall <= 1'b1;
        stall_left <= wait_len;
      end
    end else if (stall_left != 0) begin
      if (stall_left == 1) out_stall <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  // Watchdog: give up when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    longint                      level;
    int                          sel;
    int                          idx;
    int                          p;
    logic [bse_pkg::COUNT_W-1:0] count_pick;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table straight after reset.
    send(bse_pkg::CMD_SEARCH, '0, 32'sd0);
    send(bse_pkg::CMD_SEARCH, 10'd1023, KEY_MAX);

    // Small sorted table spanning both value extremes.
    send(bse_pkg::CMD_WRITE, 10'd0, KEY_MIN);
    send(bse_pkg::CMD_WRITE, 10'd1, -32'sd1000);
    send(bse_pkg::CMD_WRITE, 10'd2, -32'sd1);
    send(bse_pkg::CMD_WRITE, 10'd3, 32'sd0);
    send(bse_pkg::CMD_WRITE, 10'd4, 32'sd1);
    send(bse_pkg::CMD_WRITE, 10'd5, 32'sd1000);
    send(bse_pkg::CMD_WRITE, 10'd6, 32'sd12345);
    send(bse_pkg::CMD_WRITE, 10'd7, KEY_MAX);
    set_count(11'd8);
    send(bse_pkg::CMD_SEARCH, '0, KEY_MIN);
    send(bse_pkg::CMD_SEARCH, '0, KEY_MAX);
    send(bse_pkg::CMD_SEARCH, '0, 32'sd0);
    send(bse_pkg::CMD_SEARCH, '0, -32'sd500);
    send(bse_pkg::CMD_SEARCH, '0, 32'sd2);
    send(bse_pkg::CMD_SEARCH, '0, KEY_MAX - 1);

    // Single-entry table: a hit and a miss.
    set_count(11'd1);
    send(bse_pkg::CMD_SEARCH, '0, KEY_MIN);
    send(bse_pkg::CMD_SEARCH, '0, 32'sd5);

    // Back to an empty table with data present.
    set_count(11'd0);
    send(bse_pkg::CMD_SEARCH, '0, KEY_MIN);

    // Fill the whole table with an ascending ramp from the lowest to the highest value.
    level = longint'(KEY_MIN);
    for (idx = 0; idx < DEPTH; idx++) begin
      send_quiet = (idx < DEPTH / 2);
      if (level > longint'(KEY_MAX) || idx == DEPTH - 1) level = longint'(KEY_MAX);
      send(bse_pkg::CMD_WRITE, idx[bse_pkg::IDX_W-1:0], level[bse_pkg::DATA_W-1:0]);
      level = level + $urandom_range(0, 4194303);
    end

    // Random phases, each under its own entry count and idling style.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: count_pick = 11'd1024;
        1: count_pick = '1;
        2: count_pick = '0;
        default: begin
          sel = $urandom_range(0, 5);
          case (sel)
            0: count_pick = 11'd1;
            1: count_pick = bse_pkg::COUNT_W'($urandom_range(2, 16));
            2: count_pick = bse_pkg::COUNT_W'($urandom_range(17, 1023));
            3: count_pick = bse_pkg::COUNT_W'($urandom_range(1025, 2047));
            4: count_pick = 11'd1023;
            default: count_pick = bse_pkg::COUNT_W'($urandom_range(1, 1024));
          endcase
        end
      endcase
      set_count(count_pick);
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        // Now and then let every outstanding search finish first.
        if (sel < 2) drain(0);
        if (sel >= 90) begin
          idx = $urandom_range(0, DEPTH - 1);
          send(bse_pkg::CMD_WRITE, idx[bse_pkg::IDX_W-1:0],
               (sel < 95) ? shadow[idx[bse_pkg::IDX_W-1:0]] : $urandom);
        end else begin
          send(bse_pkg::CMD_SEARCH, bse_pkg::IDX_W'($urandom), pick_key());
        end
      end
    end

    drain(SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bse_pkg.sv
rtl/bse_ctrl.sv
rtl/bse_datapath.sv
rtl/binary_search_engine.sv
tb/binary_search_checker.sv
tb/binary_search_engine_tb.sv
